// ----- design/vpp_pkg.sv -----
package vpp_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int FOCAL_LENGTH_DEF = 300;

	// Stage counts of the three pipeline sections.
	localparam int XF_STAGES  = 3;
	localparam int DIV_STAGES = 32;
	localparam int SCR_STAGES = 3;
	localparam int NUM_STAGES = XF_STAGES + DIV_STAGES + SCR_STAGES;

	typedef enum logic [2:0] {
		REG_CAM_X    = 3'd0,
		REG_CAM_Y    = 3'd1,
		REG_CAM_Z    = 3'd2,
		REG_COS      = 3'd3,
		REG_SIN      = 3'd4,
		REG_HALF_W   = 3'd5,
		REG_HALF_H   = 3'd6,
		REG_MARGIN   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic signed [17:0] cos_v;
		logic signed [17:0] sin_v;
		logic        [11:0] half_w;
		logic        [11:0] half_h;
		logic        [30:0] margin;
	} cfg_t;

	// Values that ride alongside the divider for one projected point.
	typedef struct packed {
		logic signed [31:0] mx;   // translated X
		logic signed [31:0] ny;   // negated rotated Y
		logic signed [31:0] rz;   // rotated depth, unclamped
	} side_t;

endpackage

// ----- design/vpp_xform.sv -----
module vpp_xform import vpp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic [XF_STAGES-1:0]     en,
	input  logic signed [15:0]       vertex_x,
	input  logic signed [15:0]       vertex_y,
	input  logic signed [15:0]       vertex_z,
	input  logic signed [31:0]       offset_x,
	input  logic signed [31:0]       offset_y,
	input  logic signed [31:0]       offset_z,
	input  cfg_t                     cfg,
	output side_t                    vert,
	output logic [30:0]              vert_dz,
	output side_t                    orig,
	output logic [30:0]              orig_dz
);

	localparam logic [63:0] ONE_W = 64'(1) << FRAC_BITS;
	localparam logic signed [31:0] ONE = ONE_W[31:0];

	function automatic logic signed [31:0] fx_trunc(input logic signed [49:0] p);
		logic signed [63:0] e;
		e = 64'(p);
		return e[FRAC_BITS +: 32];
	endfunction

	function automatic logic signed [31:0] to_fix(input logic signed [15:0] v);
		logic [47:0] e;
		e = 48'(v) << FRAC_BITS;
		return e[31:0];
	endfunction

	// Stage 1: fixed-point conversion, offset and camera translation.
	logic signed [31:0] vmx_s1, vmy_s1, vmz_s1, omx_s1, omy_s1, omz_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vmx_s1 <= to_fix(vertex_x) + offset_x - cfg.cam_x;
			vmy_s1 <= to_fix(vertex_y) + offset_y - cfg.cam_y;
			vmz_s1 <= to_fix(vertex_z) + offset_z - cfg.cam_z;
			omx_s1 <= offset_x - cfg.cam_x;
			omy_s1 <= offset_y - cfg.cam_y;
			omz_s1 <= offset_z - cfg.cam_z;
		end
	end

	// Stage 2: the four rotation products for each point.
	logic signed [49:0] vyc, vzs, vys, vzc, oyc, ozs, oys, ozc;
	assign vyc = vmy_s1 * cfg.cos_v;
	assign vzs = vmz_s1 * cfg.sin_v;
	assign vys = vmy_s1 * cfg.sin_v;
	assign vzc = vmz_s1 * cfg.cos_v;
	assign oyc = omy_s1 * cfg.cos_v;
	assign ozs = omz_s1 * cfg.sin_v;
	assign oys = omy_s1 * cfg.sin_v;
	assign ozc = omz_s1 * cfg.cos_v;

	logic signed [31:0] vyc_s2, vzs_s2, vys_s2, vzc_s2, vmx_s2;
	logic signed [31:0] oyc_s2, ozs_s2, oys_s2, ozc_s2, omx_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			vyc_s2 <= fx_trunc(vyc);
			vzs_s2 <= fx_trunc(vzs);
			vys_s2 <= fx_trunc(vys);
			vzc_s2 <= fx_trunc(vzc);
			vmx_s2 <= vmx_s1;
			oyc_s2 <= fx_trunc(oyc);
			ozs_s2 <= fx_trunc(ozs);
			oys_s2 <= fx_trunc(oys);
			ozc_s2 <= fx_trunc(ozc);
			omx_s2 <= omx_s1;
		end
	end

	// Stage 3: rotated sums and the depth clamp to one unit.
	logic signed [31:0] vrz, orz;
	assign vrz = vys_s2 + vzc_s2;
	assign orz = oys_s2 + ozc_s2;

	side_t       vert_s3, orig_s3;
	logic [30:0] vdz_s3, odz_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			vert_s3.mx <= vmx_s2;
			vert_s3.ny <= vzs_s2 - vyc_s2;
			vert_s3.rz <= vrz;
			vdz_s3     <= (vrz < ONE) ? ONE[30:0] : vrz[30:0];
			orig_s3.mx <= omx_s2;
			orig_s3.ny <= ozs_s2 - oyc_s2;
			orig_s3.rz <= orz;
			odz_s3     <= (orz < ONE) ? ONE[30:0] : orz[30:0];
		end
	end

	assign vert    = vert_s3;
	assign vert_dz = vdz_s3;
	assign orig    = orig_s3;
	assign orig_dz = odz_s3;

endmodule

// ----- design/vpp_div.sv -----
module vpp_div import vpp_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int FOCAL_LENGTH = FOCAL_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [30:0]           d_in,
	input  side_t                 side_in,
	output logic signed [31:0]    scale,
	output side_t                 side_out
);

	// Focal length in fixed point, wrapped to 32 bits; its magnitude is
	// divided and the sign restored at the end.
	localparam logic [63:0] FOV_W   = 64'(FOCAL_LENGTH) << FRAC_BITS;
	localparam logic [31:0] FOV     = FOV_W[31:0];
	localparam logic        FOV_NEG = FOV[31];
	localparam logic [31:0] FOV_MAG = FOV_NEG ? (~FOV + 32'd1) : FOV;
	localparam logic [63:0] NUM     = 64'(FOV_MAG) << FRAC_BITS;
	localparam logic [30:0] REM0    = NUM[62:32];
	localparam logic [31:0] NLO     = NUM[31:0];

	logic [30:0] rem_s [DIV_STAGES];
	logic [31:0] q_s   [DIV_STAGES];
	logic [30:0] d_s   [DIV_STAGES];
	side_t       side_s[DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		logic [30:0] rem_p;
		logic [31:0] q_p;
		logic [30:0] d_p;
		side_t       side_p;
		logic [31:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_p  = REM0;
			assign q_p    = '0;
			assign d_p    = d_in;
			assign side_p = side_in;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign q_p    = q_s[k-1];
			assign d_p    = d_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign trial = {rem_p, NLO[DIV_STAGES-1-k]};
		assign ge    = trial >= {1'b0, d_p};

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= ge ? 31'(trial - {1'b0, d_p}) : trial[30:0];
				q_s[k]    <= {q_p[30:0], ge};
				d_s[k]    <= d_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign scale    = FOV_NEG ? -q_s[DIV_STAGES-1] : q_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule

// ----- design/vpp_scr.sv -----
module vpp_scr import vpp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic [SCR_STAGES-1:0] en,
	input  logic signed [31:0]    vert_scale,
	input  side_t                 vert,
	input  logic signed [31:0]    orig_scale,
	input  side_t                 orig,
	input  cfg_t                  cfg,
	output logic signed [31:0]    screen_x,
	output logic signed [31:0]    screen_y,
	output logic signed [31:0]    view_depth,
	output logic                  in_range
);

	logic signed [63:0] pvx, pvy, pox, poy;
	assign pvx = vert.mx * vert_scale;
	assign pvy = vert.ny * vert_scale;
	assign pox = orig.mx * orig_scale;
	assign poy = orig.ny * orig_scale;

	// Stage 1: scale products.
	logic signed [31:0] vx_s1, vy_s1, ox_s1, oy_s1, vz_s1, oz_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vx_s1 <= pvx[FRAC_BITS +: 32];
			vy_s1 <= pvy[FRAC_BITS +: 32];
			ox_s1 <= pox[FRAC_BITS +: 32];
			oy_s1 <= poy[FRAC_BITS +: 32];
			vz_s1 <= vert.rz;
			oz_s1 <= orig.rz;
		end
	end

	logic [63:0] hw_e, hh_e, sw_e, sh_e;
	logic signed [31:0] margin32;
	assign hw_e     = 64'(cfg.half_w) << FRAC_BITS;
	assign hh_e     = 64'(cfg.half_h) << FRAC_BITS;
	assign sw_e     = 64'(cfg.half_w) << (FRAC_BITS + 1);
	assign sh_e     = 64'(cfg.half_h) << (FRAC_BITS + 1);
	assign margin32 = {1'b0, cfg.margin};

	// Stage 2: screen centering and range bounds.
	logic signed [31:0] sx_s2, sy_s2, cx_s2, cy_s2, vz_s2, oz_s2;
	logic signed [31:0] hix_s2, hiy_s2, lo_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sx_s2  <= vx_s1 + hw_e[31:0];
			sy_s2  <= vy_s1 + hh_e[31:0];
			cx_s2  <= ox_s1 + hw_e[31:0];
			cy_s2  <= oy_s1 + hh_e[31:0];
			vz_s2  <= vz_s1;
			oz_s2  <= oz_s1;
			hix_s2 <= sw_e[31:0] + margin32;
			hiy_s2 <= sh_e[31:0] + margin32;
			lo_s2  <= -margin32;
		end
	end

	// Stage 3: range test on the projected origin; output register.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			screen_x   <= sx_s2;
			screen_y   <= sy_s2;
			view_depth <= vz_s2;
			in_range   <= (oz_s2 > margin32) && !(cx_s2 > hix_s2) && !(cx_s2 < lo_s2)
				&& !(cy_s2 > hiy_s2) && !(cy_s2 < lo_s2);
		end
	end

endmodule

// ----- design/vertex_perspective_projection.sv -----
// Perspective projection of model vertices with camera pitch. Each item on the
// slave stream is one integer vertex plus a Q16.16 world offset; each item on the
// master stream is its screen X and Y, the unclamped rotated depth and an
// in-range flag (the flag is judged on the projected offset point, the vertex's
// model origin). The block takes one item per clock while the output is not
// held off. It is a pipeline of translation and rotation stages, quotient
// stages producing one quotient bit per stage for the focal-length-over-depth
// scale, and scaling, centering and range-test stages. Every stage has its own
// valid bit, so a stall on the output only backs up the stages that hold items
// and bubbles are squeezed out. Camera, pitch, screen size and margin are set
// through the register port and should only be changed while no item is in
// flight.
module vertex_perspective_projection import vpp_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int FOCAL_LENGTH = FOCAL_LENGTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input item stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, from bit 0: vertex_x[15:0], vertex_y[15:0], vertex_z[15:0],
	// offset_x[31:0], offset_y[31:0], offset_z[31:0].
	input  logic [143:0] s_tdata,
	// Result item stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, from bit 0: screen_x[31:0], screen_y[31:0], view_depth[31:0].
	output logic [95:0]  m_tdata,
	// m_tuser, from bit 0: in_range.
	output logic         m_tuser,
	// Register port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	// Configuration registers; a write lands on the access cycle.
	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_x  <= '0;
			cfg_q.cam_y  <= '0;
			cfg_q.cam_z  <= '0;
			cfg_q.cos_v  <= 18'sd65536;
			cfg_q.sin_v  <= '0;
			cfg_q.half_w <= 12'd198;
			cfg_q.half_h <= 12'd112;
			cfg_q.margin <= 31'd2097152;
		end else if (wr) begin
			unique case (idx)
				REG_CAM_X:  cfg_q.cam_x  <= pwdata;
				REG_CAM_Y:  cfg_q.cam_y  <= pwdata;
				REG_CAM_Z:  cfg_q.cam_z  <= pwdata;
				REG_COS:    cfg_q.cos_v  <= pwdata[17:0];
				REG_SIN:    cfg_q.sin_v  <= pwdata[17:0];
				REG_HALF_W: cfg_q.half_w <= pwdata[11:0];
				REG_HALF_H: cfg_q.half_h <= pwdata[11:0];
				REG_MARGIN: cfg_q.margin <= pwdata[30:0];
				default:    ;
			endcase
		end
	end

	// Reads return each register sign- or zero-extended to the bus width.
	always_comb begin
		unique case (idx)
			REG_CAM_X:  prdata = cfg_q.cam_x;
			REG_CAM_Y:  prdata = cfg_q.cam_y;
			REG_CAM_Z:  prdata = cfg_q.cam_z;
			REG_COS:    prdata = 32'(cfg_q.cos_v);
			REG_SIN:    prdata = 32'(cfg_q.sin_v);
			REG_HALF_W: prdata = {20'd0, cfg_q.half_w};
			REG_HALF_H: prdata = {20'd0, cfg_q.half_h};
			REG_MARGIN: prdata = {1'b0, cfg_q.margin};
			default:    prdata = '0;
		endcase
	end

	// Pipeline control. A stage loads when it is empty or when the stage after
	// it loads in the same cycle; the last stage drains to the master side.
	logic [NUM_STAGES-1:0] v_q;
	logic [NUM_STAGES-1:0] en;

	always_comb begin
		en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_tready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= s_tvalid;
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[NUM_STAGES-1];

	// Datapath.
	side_t              vert_xf, orig_xf, vert_dv, orig_dv;
	logic [30:0]        vert_dz, orig_dz;
	logic signed [31:0] vert_scale, orig_scale;
	logic signed [31:0] screen_x, screen_y, view_depth;
	logic               in_range;

	vpp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
		.clk      (clk),
		.en       (en[XF_STAGES-1:0]),
		.vertex_x (s_tdata[15:0]),
		.vertex_y (s_tdata[31:16]),
		.vertex_z (s_tdata[47:32]),
		.offset_x (s_tdata[79:48]),
		.offset_y (s_tdata[111:80]),
		.offset_z (s_tdata[143:112]),
		.cfg      (cfg_q),
		.vert     (vert_xf),
		.vert_dz  (vert_dz),
		.orig     (orig_xf),
		.orig_dz  (orig_dz)
	);

	vpp_div #(.FRAC_BITS(FRAC_BITS), .FOCAL_LENGTH(FOCAL_LENGTH)) u_div_vert (
		.clk      (clk),
		.en       (en[XF_STAGES +: DIV_STAGES]),
		.d_in     (vert_dz),
		.side_in  (vert_xf),
		.scale    (vert_scale),
		.side_out (vert_dv)
	);

	vpp_div #(.FRAC_BITS(FRAC_BITS), .FOCAL_LENGTH(FOCAL_LENGTH)) u_div_orig (
		.clk      (clk),
		.en       (en[XF_STAGES +: DIV_STAGES]),
		.d_in     (orig_dz),
		.side_in  (orig_xf),
		.scale    (orig_scale),
		.side_out (orig_dv)
	);

	vpp_scr #(.FRAC_BITS(FRAC_BITS)) u_scr (
		.clk        (clk),
		.en         (en[XF_STAGES+DIV_STAGES +: SCR_STAGES]),
		.vert_scale (vert_scale),
		.vert       (vert_dv),
		.orig_scale (orig_scale),
		.orig       (orig_dv),
		.cfg        (cfg_q),
		.screen_x   (screen_x),
		.screen_y   (screen_y),
		.view_depth (view_depth),
		.in_range   (in_range)
	);

	assign m_tdata = {view_depth, screen_y, screen_x};
	assign m_tuser = in_range;

	// A full pipeline with a stalled output must refuse new items.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&v_q) && !m_tready |-> !s_tready)
		else $error("input accepted while pipeline full and stalled");

	// An accepted item occupies the first stage on the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_q[0])
		else $error("accepted item lost at pipeline entry");

	// An item in the last stage leaves only through a handshake.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NUM_STAGES-1] && !m_tready && !v_q[NUM_STAGES-2] |=> v_q[NUM_STAGES-1])
		else $error("result dropped without handshake");

	// A cosine write takes the low bits of the write data.
	a_cos_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr && idx == REG_COS |=> cfg_q.cos_v == $past(pwdata[17:0]))
		else $error("pitch cosine register not written");

endmodule
